// ===== hdl/bid_pkg.sv =====
`default_nettype none

package bid_pkg;

	localparam int unsigned IDLE_W  = 24;
	localparam int unsigned RAMP_W  = 16;
	localparam int unsigned LEVEL_W = 4;
	localparam int unsigned DUTY_W  = 8;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 24;

	localparam logic [LEVEL_W-1:0] LEVEL_MAX = 4'd8;
	localparam logic [IDLE_W-1:0]  IDLE_MAX  = 24'hFFFFFF;
	localparam logic [DUTY_W-1:0]  DUTY_FULL = 8'd255;

	localparam logic [RAMP_W-1:0] RAMP_STEP_RST    = 16'd50;
	localparam logic [IDLE_W-1:0] DIM_TIMEOUT_RST  = 24'd10000;
	localparam logic [IDLE_W-1:0] KILL_TIMEOUT_RST = 24'd60000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RAMP_STEP    = 2'd0,
		REG_DIM_TIMEOUT  = 2'd1,
		REG_KILL_TIMEOUT = 2'd2
	} reg_idx_t;

	// active-low drive: full level drives the line hard on
	function automatic logic [DUTY_W-1:0] duty_for(input logic [LEVEL_W-1:0] lvl);
		logic [DUTY_W-1:0] bit_val;
		bit_val = '0;
		if (lvl >= LEVEL_MAX) begin
			duty_for = '0;
		end else begin
			bit_val[lvl[2:0]] = 1'b1;
			duty_for = DUTY_FULL - bit_val;
		end
	endfunction

endpackage

`default_nettype wire

// ===== hdl/bid_tick_if.sv =====
`default_nettype none

interface bid_tick_if;
	logic valid;
	logic ready;
	logic button_pressed;

	modport source (output valid, output button_pressed, input ready);
	modport sink (input valid, input button_pressed, output ready);
endinterface

`default_nettype wire

// ===== hdl/bid_result_if.sv =====
`default_nettype none

interface bid_result_if
	import bid_pkg::*;
;
	logic               valid;
	logic               ready;
	logic [LEVEL_W-1:0] level;
	logic [DUTY_W-1:0]  pwm_duty;
	logic               go_home;

	modport source (output valid, output level, output pwm_duty, output go_home, input ready);
	modport sink (input valid, input level, input pwm_duty, input go_home, output ready);
endinterface

`default_nettype wire

// ===== hdl/bid_cfg_if.sv =====
`default_nettype none

interface bid_cfg_if
	import bid_pkg::*;
;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/backlight_inactivity_dimmer.sv =====
// Channel  Dir  Payload                          Handshake
// tick     in   button_pressed                   valid/ready
// result   out  level, pwm_duty, go_home         valid/ready
// cfg      in   index, data                      valid/ready (always ready)
//
// One word per cycle unless the result stalls: a tick is captured in an
// input register, the state update runs in one pass and lands in the
// result register with the state, where the result then shows as valid.
// A stalled result holds; one more tick may wait in the input register.
// arst_n resets state and config to defaults; data regs are not reset.
`default_nettype none

module backlight_inactivity_dimmer
	import bid_pkg::*;
(
	input  wire          clk,
	input  wire          arst_n,
	bid_tick_if.sink     tick,
	bid_result_if.source result,
	bid_cfg_if.sink      cfg
);

	logic [RAMP_W-1:0] ramp_step_q;
	logic [IDLE_W-1:0] dim_timeout_q;
	logic [IDLE_W-1:0] kill_timeout_q;

	logic [IDLE_W-1:0]  idle_q;
	logic               lit_q;
	logic [LEVEL_W-1:0] bright_level_q;
	logic [RAMP_W-1:0]  ramp_q;
	logic               home_sent_q;

	logic valid_s1;
	logic button_s1;

	logic               out_valid_q;
	logic [LEVEL_W-1:0] level_q;
	logic [DUTY_W-1:0]  duty_q;
	logic               go_home_q;

	logic advance;

	logic [IDLE_W-1:0]  idle_n;
	logic               lit_n;
	logic               home_n;
	logic               pulse;
	logic               move_up;
	logic               move_dn;
	logic [LEVEL_W-1:0] level_n;
	logic [RAMP_W-1:0]  ramp_n;

	assign advance    = !out_valid_q || result.ready;
	assign tick.ready = !valid_s1 || advance;
	assign cfg.ready  = 1'b1;

	assign result.valid    = out_valid_q;
	assign result.level    = level_q;
	assign result.pwm_duty = duty_q;
	assign result.go_home  = go_home_q;

	always_comb begin
		idle_n = idle_q;
		lit_n  = lit_q;
		home_n = home_sent_q;
		pulse  = 1'b0;
		if (button_s1) begin
			idle_n = '0;
			lit_n  = 1'b1;
			home_n = 1'b0;
		end else begin
			if (idle_q != IDLE_MAX) begin
				idle_n = idle_q + 1'b1;
			end
			if (idle_n >= dim_timeout_q) begin
				lit_n = 1'b0;
			end
			if (idle_n >= kill_timeout_q && !home_sent_q) begin
				pulse  = 1'b1;
				home_n = 1'b1;
			end
		end

		move_up = lit_n && (bright_level_q < LEVEL_MAX);
		move_dn = !lit_n && (bright_level_q != '0);
		level_n = bright_level_q;
		ramp_n  = '0;
		if (move_up || move_dn) begin
			if (ramp_q == '0) begin
				level_n = move_up ? bright_level_q + 1'b1 : bright_level_q - 1'b1;
				// a zero period behaves as one step per tick
				ramp_n  = (ramp_step_q == '0) ? '0 : ramp_step_q - 1'b1;
			end else begin
				ramp_n = ramp_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ramp_step_q    <= RAMP_STEP_RST;
			dim_timeout_q  <= DIM_TIMEOUT_RST;
			kill_timeout_q <= KILL_TIMEOUT_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_RAMP_STEP:    ramp_step_q    <= cfg.data[RAMP_W-1:0];
				REG_DIM_TIMEOUT:  dim_timeout_q  <= cfg.data[IDLE_W-1:0];
				REG_KILL_TIMEOUT: kill_timeout_q <= cfg.data[IDLE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick.ready) begin
			valid_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready) begin
			button_s1 <= tick.button_pressed;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_q         <= '0;
			lit_q          <= 1'b1;
			bright_level_q <= '0;
			ramp_q         <= '0;
			home_sent_q    <= 1'b0;
			out_valid_q    <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				idle_q         <= idle_n;
				lit_q          <= lit_n;
				bright_level_q <= level_n;
				ramp_q         <= ramp_n;
				home_sent_q    <= home_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			level_q   <= level_n;
			duty_q    <= duty_for(level_n);
			go_home_q <= pulse;
		end
	end

`ifndef SYNTHESIS
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		bright_level_q <= LEVEL_MAX)
		else $error("brightness level out of range");

	a_level_step: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (bright_level_q == $past(bright_level_q)) ||
			(bright_level_q == $past(bright_level_q) + 1'b1) ||
			(bright_level_q == $past(bright_level_q) - 1'b1))
		else $error("brightness level moved by more than one step");

	a_home_marked: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && go_home_q) |-> home_sent_q)
		else $error("go_home pulse without home_sent set");

	a_result_level: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (level_q == bright_level_q))
		else $error("shown level differs from held level");
`endif

endmodule

`default_nettype wire
